>>> hdl/pcs_pkg.sv
// Package: shared types and constants for the precharge contactor sequencer.
package pcs_pkg;

	localparam int PT_W        = 13;
	localparam int OVL_W       = 16;
	localparam int CFG_DATA_W  = 16;
	localparam int CFG_INDEX_W = 2;
	localparam int PHASE_W     = 3;

	localparam logic [PT_W-1:0]  PT_RESET  = 13'd50;
	localparam logic [OVL_W-1:0] OVL_RESET = 16'd100;

	localparam logic [CFG_INDEX_W-1:0] CFG_IDX_PRECHARGE_TIME = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_IDX_OVERLAP_TICKS  = 2'd1;

	typedef enum logic [1:0] {
		ACT_TICK_10MS = 2'd0,
		ACT_TICK_1S   = 2'd1,
		ACT_CLOSE_REQ = 2'd2,
		ACT_OPEN_ALL  = 2'd3
	} action_t;

	localparam logic [PHASE_W-1:0] PHASE_IDLE       = 3'd0;
	localparam logic [PHASE_W-1:0] PHASE_CLOSE_PRE  = 3'd1;
	localparam logic [PHASE_W-1:0] PHASE_PRE_WAIT   = 3'd2;
	localparam logic [PHASE_W-1:0] PHASE_CLOSE_MAIN = 3'd3;
	localparam logic [PHASE_W-1:0] PHASE_OVERLAP    = 3'd4;

	typedef enum logic [4:0] {
		ST_IDLE       = 5'b00001,
		ST_CLOSE_PRE  = 5'b00010,
		ST_PRE_WAIT   = 5'b00100,
		ST_CLOSE_MAIN = 5'b01000,
		ST_OVERLAP    = 5'b10000
	} seq_state_t;

	typedef struct packed {
		action_t action;
		logic    relay_already_on;
		logic    engineering_mode;
		logic    system_ready;
		logic    protection_active;
	} req_t;

	typedef struct packed {
		logic               precharge_relay;
		logic               main_relays;
		logic               relay_supply;
		logic               relay_on_pulse;
		logic [PHASE_W-1:0] phase;
	} res_t;

	typedef struct packed {
		logic [PT_W-1:0]  precharge_time;
		logic [OVL_W-1:0] overlap_ticks;
	} cfg_t;

	function automatic logic [PHASE_W-1:0] phase_code(input seq_state_t st);
		logic [PHASE_W-1:0] code;
		case (st)
			ST_IDLE:       code = PHASE_IDLE;
			ST_CLOSE_PRE:  code = PHASE_CLOSE_PRE;
			ST_PRE_WAIT:   code = PHASE_PRE_WAIT;
			ST_CLOSE_MAIN: code = PHASE_CLOSE_MAIN;
			ST_OVERLAP:    code = PHASE_OVERLAP;
			default:       code = PHASE_IDLE;
		endcase
		return code;
	endfunction

endpackage

>>> hdl/precharge_contactor_sequencer.sv
// Top level: precharge / main contactor sequencer with request and result registers.
// A request waits in the input register, then its result loads the result register.
// Throughput: one request per cycle unless out_stall holds the full result register;
// the two form a two-stage pipe; the sequencer state updates once per request.
// Reset: arst_n (async, active low) returns to idle with all relays open,
// supply off, no pending close, counter zero; precharge_time 50, overlap 100.
module precharge_contactor_sequencer import pcs_pkg::*; #(
	parameter int COUNT_WIDTH    = 16,
	parameter int TICKS_PER_UNIT = 10
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration write port
	input  logic                   cfg_write_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	// request channel
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [1:0]             action,
	input  logic                   relay_already_on,
	input  logic                   engineering_mode,
	input  logic                   system_ready,
	input  logic                   protection_active,
	// result channel
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic                   precharge_relay,
	output logic                   main_relays,
	output logic                   relay_supply,
	output logic                   relay_on_pulse,
	output logic [PHASE_W-1:0]     phase
);

	logic valid_s1;
	req_t req_s1;
	logic out_valid_q;
	logic advance;
	logic fire;
	cfg_t cfg;
	res_t res;

	// The result register moves on when it is empty or being taken.
	assign advance  = !out_valid_q || !out_stall;
	// Stage 1 holds only while its request cannot move into the result register.
	assign in_stall = valid_s1 && !advance;
	assign fire     = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	// Request payload register; no reset needed.
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			req_s1.action            <= action_t'(action);
			req_s1.relay_already_on  <= relay_already_on;
			req_s1.engineering_mode  <= engineering_mode;
			req_s1.system_ready      <= system_ready;
			req_s1.protection_active <= protection_active;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	pcs_cfg_regs u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write_en (cfg_write_en),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cfg          (cfg)
	);

	// Sequencer: state and the result register both load on fire.
	pcs_seq_core #(
		.COUNT_WIDTH    (COUNT_WIDTH),
		.TICKS_PER_UNIT (TICKS_PER_UNIT)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.req    (req_s1),
		.cfg    (cfg),
		.res    (res)
	);

	assign out_valid       = out_valid_q;
	assign precharge_relay = res.precharge_relay;
	assign main_relays     = res.main_relays;
	assign relay_supply    = res.relay_supply;
	assign relay_on_pulse  = res.relay_on_pulse;
	assign phase           = res.phase;

endmodule

>>> hdl/pcs_cfg_regs.sv
// Configuration registers: precharge time and overlap tick count.
module pcs_cfg_regs import pcs_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_write_en,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	output cfg_t                   cfg
);

	logic [PT_W-1:0]  precharge_time_q;
	logic [OVL_W-1:0] overlap_ticks_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			precharge_time_q <= PT_RESET;
			overlap_ticks_q  <= OVL_RESET;
		end else if (cfg_write_en) begin
			case (cfg_index)
				CFG_IDX_PRECHARGE_TIME: precharge_time_q <= cfg_data[PT_W-1:0];
				CFG_IDX_OVERLAP_TICKS:  overlap_ticks_q  <= cfg_data[OVL_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg.precharge_time = precharge_time_q;
	assign cfg.overlap_ticks  = overlap_ticks_q;

endmodule

>>> hdl/pcs_seq_core.sv
// Sequencer state, next-state logic and result register.
module pcs_seq_core import pcs_pkg::*; #(
	parameter int COUNT_WIDTH    = 16,
	parameter int TICKS_PER_UNIT = 10
) (
	input  logic clk,
	input  logic arst_n,
	input  logic fire,
	input  req_t req,
	input  cfg_t cfg,
	output res_t res
);

	localparam int PROD_W = PT_W + $clog2(TICKS_PER_UNIT + 1);
	localparam int W_A    = (PROD_W > COUNT_WIDTH) ? PROD_W : COUNT_WIDTH;
	localparam int CMP_W  = (W_A > OVL_W) ? W_A : OVL_W;
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

	seq_state_t             state_q, state_d;
	logic                   close_req_q, close_req_d;
	logic [COUNT_WIDTH-1:0] tick_count_q, tick_count_d;
	logic                   pre_q, pre_d;
	logic                   main_q, main_d;
	logic                   supply_q, supply_d;
	logic                   pulse_d;
	res_t                   res_s2;

	logic [COUNT_WIDTH-1:0] cnt_inc;
	logic [CMP_W-1:0]       pre_target;
	logic                   pre_done;
	logic                   ovl_done;
	logic                   start_ok;

	// saturating count; a target above the counter range ends at saturation
	assign cnt_inc    = (tick_count_q == CNT_MAX) ? tick_count_q
	                                              : tick_count_q + 1'b1;
	assign pre_target = CMP_W'(cfg.precharge_time) * CMP_W'(TICKS_PER_UNIT);
	assign pre_done   = (CMP_W'(cnt_inc) >= pre_target) || (cnt_inc == CNT_MAX);
	assign ovl_done   = CMP_W'(cnt_inc) >= CMP_W'(cfg.overlap_ticks);
	assign start_ok   = !req.relay_already_on && !req.engineering_mode &&
	                    close_req_q && req.system_ready &&
	                    !req.protection_active && (state_q == ST_IDLE);

	always_comb begin
		state_d      = state_q;
		close_req_d  = close_req_q;
		tick_count_d = tick_count_q;
		pre_d        = pre_q;
		main_d       = main_q;
		supply_d     = supply_q;
		pulse_d      = 1'b0;
		case (req.action)
			ACT_TICK_10MS: begin
				case (state_q)
					ST_IDLE: ;
					ST_CLOSE_PRE: begin
						tick_count_d = '0;
						pre_d        = 1'b1;
						state_d      = ST_PRE_WAIT;
					end
					ST_PRE_WAIT: begin
						tick_count_d = cnt_inc;
						if (pre_done) begin
							state_d = ST_CLOSE_MAIN;
						end
					end
					ST_CLOSE_MAIN: begin
						tick_count_d = '0;
						main_d       = 1'b1;
						pulse_d      = 1'b1;
						state_d      = ST_OVERLAP;
					end
					ST_OVERLAP: begin
						tick_count_d = cnt_inc;
						if (ovl_done) begin
							pre_d       = 1'b0;
							close_req_d = 1'b0;
							state_d     = ST_IDLE;
						end
					end
					default: state_d = ST_IDLE;
				endcase
			end
			ACT_TICK_1S: begin
				if (start_ok) begin
					state_d  = ST_CLOSE_PRE;
					supply_d = 1'b1;
				end
			end
			ACT_CLOSE_REQ: close_req_d = 1'b1;
			ACT_OPEN_ALL: begin
				supply_d     = 1'b0;
				main_d       = 1'b0;
				pre_d        = 1'b0;
				state_d      = ST_IDLE;
				close_req_d  = 1'b0;
				tick_count_d = '0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			close_req_q  <= 1'b0;
			tick_count_q <= '0;
			pre_q        <= 1'b0;
			main_q       <= 1'b0;
			supply_q     <= 1'b0;
		end else if (fire) begin
			state_q      <= state_d;
			close_req_q  <= close_req_d;
			tick_count_q <= tick_count_d;
			pre_q        <= pre_d;
			main_q       <= main_d;
			supply_q     <= supply_d;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2.precharge_relay <= pre_d;
			res_s2.main_relays     <= main_d;
			res_s2.relay_supply    <= supply_d;
			res_s2.relay_on_pulse  <= pulse_d;
			res_s2.phase           <= phase_code(state_d);
		end
	end

	assign res = res_s2;

endmodule

>>> hdl/pcs_checker.sv
// Port-level checker for the sequencer, bound to the top level.
module pcs_checker import pcs_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input logic               precharge_relay,
	input logic               main_relays,
	input logic               relay_supply,
	input logic               relay_on_pulse,
	input logic [PHASE_W-1:0] phase
);

	// main relays never closed without coil supply
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && main_relays |-> relay_supply)
		else $error("main relays closed without supply");

	// relay-on pulse comes with main closed and the overlap phase
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && relay_on_pulse |-> main_relays && (phase == PHASE_OVERLAP))
		else $error("relay-on pulse outside main close step");

	// from precharge wait through overlap the precharge relay is closed and supply on
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ((phase == PHASE_PRE_WAIT) || (phase == PHASE_CLOSE_MAIN)
			|| (phase == PHASE_OVERLAP)) |-> precharge_relay && relay_supply)
		else $error("precharge relay open during sequence");

	// stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(phase)
			&& $stable(precharge_relay) && $stable(main_relays)
			&& $stable(relay_supply) && $stable(relay_on_pulse))
		else $error("stalled result changed");

endmodule

bind precharge_contactor_sequencer pcs_checker u_pcs_checker (.*);

>>> verif/tb_top.sv
// Testbench for the precharge contactor sequencer: directed table, long run, random phases.
module tb_top;
	import pcs_pkg::*;

	localparam int          SEQ_COUNT_W    = 16;
	localparam int          TICKS_PER_UNIT = 10;
	localparam int unsigned COUNT_MAX      = (1 << SEQ_COUNT_W) - 1;

	// indexes past the last register; writes there must be ignored
	localparam logic [CFG_INDEX_W-1:0] CFG_IDX_SPARE_A = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_IDX_SPARE_B = 2'd3;

	// status flag nibbles in port order: {already_on, eng_mode, ready, protection}
	localparam logic [3:0] F_NONE  = 4'b0000;
	localparam logic [3:0] F_READY = 4'b0010;
	localparam logic [3:0] F_ON    = 4'b1010;
	localparam logic [3:0] F_ENG   = 4'b0110;
	localparam logic [3:0] F_PROT  = 4'b0011;
	localparam logic [3:0] F_ALL   = 4'b1101;

	// levels that can be read straight off the sequence description
	localparam res_t LV_OPEN      = '0;
	localparam res_t LV_STARTED   = {1'b0, 1'b0, 1'b1, 1'b0, PHASE_CLOSE_PRE};
	localparam res_t LV_PRECHARGE = {1'b1, 1'b0, 1'b1, 1'b0, PHASE_PRE_WAIT};
	localparam res_t LV_MAIN_ON   = {1'b1, 1'b1, 1'b1, 1'b1, PHASE_OVERLAP};

	typedef struct packed {
		logic                   is_reg;
		logic [CFG_INDEX_W-1:0] reg_index;
		logic [CFG_DATA_W-1:0]  reg_value;
		req_t                   req;
		logic                   has_want;
		res_t                   want;
	} step_t;

	logic                   clk               = 1'b0;
	logic                   arst_n            = 1'b0;
	logic                   cfg_write_en      = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index         = '0;
	logic [CFG_DATA_W-1:0]  cfg_data          = '0;
	logic                   in_valid          = 1'b0;
	logic                   in_stall;
	logic [1:0]             action            = '0;
	logic                   relay_already_on  = 1'b0;
	logic                   engineering_mode  = 1'b0;
	logic                   system_ready      = 1'b0;
	logic                   protection_active = 1'b0;
	logic                   out_valid;
	logic                   out_stall         = 1'b0;
	logic                   precharge_relay;
	logic                   main_relays;
	logic                   relay_supply;
	logic                   relay_on_pulse;
	logic [PHASE_W-1:0]     phase;

	// sequencer state as the testbench sees it
	logic [PHASE_W-1:0] seq_ph        = PHASE_IDLE;
	logic               close_pending = 1'b0;
	int unsigned        tick_cnt      = 0;
	logic               pre_lvl       = 1'b0;
	logic               main_lvl      = 1'b0;
	logic               supply_lvl    = 1'b0;
	logic [PT_W-1:0]    pre_time      = PT_RESET;
	logic [OVL_W-1:0]   overlap       = OVL_RESET;

	res_t        pending_levels[$];
	int unsigned failures       = 0;
	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;

	step_t directed_steps [26];

	precharge_contactor_sequencer #(
		.COUNT_WIDTH   (SEQ_COUNT_W),
		.TICKS_PER_UNIT(TICKS_PER_UNIT)
	) uut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_write_en     (cfg_write_en),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.action           (action),
		.relay_already_on (relay_already_on),
		.engineering_mode (engineering_mode),
		.system_ready     (system_ready),
		.protection_active(protection_active),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.precharge_relay  (precharge_relay),
		.main_relays      (main_relays),
		.relay_supply     (relay_supply),
		.relay_on_pulse   (relay_on_pulse),
		.phase            (phase)
	);

	always #5 clk = ~clk;

	// Advance the sequencer by one request and return the levels after it.
	function automatic res_t contactor_step(input req_t r);
		logic        pulse;
		int unsigned wait_target;
		pulse = 1'b0;
		case (r.action)
			ACT_TICK_10MS: begin
				case (seq_ph)
					PHASE_IDLE: ;
					PHASE_CLOSE_PRE: begin
						tick_cnt = 0;
						pre_lvl  = 1'b1;
						seq_ph   = PHASE_PRE_WAIT;
					end
					PHASE_PRE_WAIT: begin
						if (tick_cnt < COUNT_MAX)
							tick_cnt++;
						// an oversized wait is clipped to the counter range so it still ends
						wait_target = pre_time * TICKS_PER_UNIT;
						if (wait_target > COUNT_MAX)
							wait_target = COUNT_MAX;
						if (tick_cnt >= wait_target)
							seq_ph = PHASE_CLOSE_MAIN;
					end
					PHASE_CLOSE_MAIN: begin
						tick_cnt = 0;
						main_lvl = 1'b1;
						pulse    = 1'b1;
						seq_ph   = PHASE_OVERLAP;
					end
					PHASE_OVERLAP: begin
						if (tick_cnt < COUNT_MAX)
							tick_cnt++;
						if (tick_cnt >= overlap) begin
							pre_lvl       = 1'b0;
							close_pending = 1'b0;
							seq_ph        = PHASE_IDLE;
						end
					end
					default: seq_ph = PHASE_IDLE;
				endcase
			end
			ACT_TICK_1S: begin
				if (!r.relay_already_on && !r.engineering_mode && close_pending &&
						r.system_ready && !r.protection_active && seq_ph == PHASE_IDLE) begin
					seq_ph     = PHASE_CLOSE_PRE;
					supply_lvl = 1'b1;
				end
			end
			ACT_CLOSE_REQ: close_pending = 1'b1;
			ACT_OPEN_ALL: begin
				supply_lvl    = 1'b0;
				main_lvl      = 1'b0;
				pre_lvl       = 1'b0;
				seq_ph        = PHASE_IDLE;
				close_pending = 1'b0;
				tick_cnt      = 0;
			end
			default: ;
		endcase
		return {pre_lvl, main_lvl, supply_lvl, pulse, seq_ph};
	endfunction

	function automatic step_t req_row(input action_t a, input logic [3:0] flags);
		step_t s;
		s     = '0;
		s.req = {a, flags};
		return s;
	endfunction

	function automatic step_t chk_row(input action_t a, input logic [3:0] flags,
			input res_t want);
		step_t s;
		s          = req_row(a, flags);
		s.has_want = 1'b1;
		s.want     = want;
		return s;
	endfunction

	function automatic step_t reg_row(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		step_t s;
		s           = '0;
		s.is_reg    = 1'b1;
		s.reg_index = idx;
		s.reg_value = value;
		return s;
	endfunction

	// Mostly 10 ms ticks so sequences run to the end; flags mostly allow a start.
	function automatic req_t random_req();
		req_t        r;
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 64)
			r.action = ACT_TICK_10MS;
		else if (pick < 80)
			r.action = ACT_TICK_1S;
		else if (pick < 96)
			r.action = ACT_CLOSE_REQ;
		else
			r.action = ACT_OPEN_ALL;
		r.relay_already_on  = ($urandom_range(99) < 12);
		r.engineering_mode  = ($urandom_range(99) < 12);
		r.system_ready      = ($urandom_range(99) < 85);
		r.protection_active = ($urandom_range(99) < 12);
		return r;
	endfunction

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			failures++;
		end
	endfunction

	// Drop valid and wait until every outstanding result is back.
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_levels.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Register writes only happen with the pipe empty.
	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		settle();
		cfg_write_en <= 1'b1;
		cfg_index    <= idx;
		cfg_data     <= value;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		case (idx)
			CFG_IDX_PRECHARGE_TIME: pre_time = value[PT_W-1:0];
			CFG_IDX_OVERLAP_TICKS:  overlap  = value[OVL_W-1:0];
			default: ;
		endcase
	endtask

	// Offer one request, hold it until taken, then queue its expected levels.
	// A typed-in expectation replaces the predicted one; the state still advances.
	task automatic apply_request(input req_t r, input logic has_want, input res_t want);
		res_t predicted;
		in_valid          <= 1'b1;
		action            <= r.action;
		relay_already_on  <= r.relay_already_on;
		engineering_mode  <= r.engineering_mode;
		system_ready      <= r.system_ready;
		protection_active <= r.protection_active;
		do
			@(posedge clk);
		while (in_stall !== 1'b0);
		predicted = contactor_step(r);
		pending_levels.push_back(has_want ? want : predicted);
		// sender gap, decided once per request
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < send_idle_pct);
		end
	endtask

	// Result side: compare each accepted result, then pick the next stall level.
	always @(posedge clk) begin
		res_t got;
		res_t want;
		if (out_valid === 1'b1 && out_stall === 1'b0) begin
			got = {precharge_relay, main_relays, relay_supply, relay_on_pulse, phase};
			if (pending_levels.size() == 0) begin
				$error("result with no request outstanding: %b", got);
				failures++;
			end else begin
				want = pending_levels.pop_front();
				check_field("precharge_relay", want.precharge_relay, got.precharge_relay);
				check_field("main_relays", want.main_relays, got.main_relays);
				check_field("relay_supply", want.relay_supply, got.relay_supply);
				check_field("relay_on_pulse", want.relay_on_pulse, got.relay_on_pulse);
				check_field("phase", want.phase, got.phase);
			end
		end
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	initial begin
		#10_000_000;
		$display("Test completed with failures");
		$finish;
	end

	initial begin
		req_t        r;
		int unsigned pt_pick  [5];
		int unsigned ovl_pick [5];
		int unsigned send_pick[5];
		int unsigned recv_pick[5];
		int unsigned ovl_val;

		pt_pick   = '{0, 1, 2, 0, 3};
		ovl_pick  = '{0, 1, 9, 0, 2};
		send_pick = '{0, 70, 0, 35, 0};
		recv_pick = '{0, 0, 70, 35, 0};

		directed_steps = '{
			// reset settings: 50 units of precharge, 100 ticks of overlap
			chk_row(ACT_TICK_10MS, F_NONE,  LV_OPEN),      // tick while idle
			chk_row(ACT_TICK_1S,   F_READY, LV_OPEN),      // no close request yet
			chk_row(ACT_CLOSE_REQ, F_ALL,   LV_OPEN),
			chk_row(ACT_TICK_1S,   F_PROT,  LV_OPEN),      // protection blocks
			chk_row(ACT_TICK_1S,   F_ENG,   LV_OPEN),      // engineering mode blocks
			chk_row(ACT_TICK_1S,   F_ON,    LV_OPEN),      // relays reported on
			chk_row(ACT_TICK_1S,   F_NONE,  LV_OPEN),      // not ready
			chk_row(ACT_TICK_1S,   F_READY, LV_STARTED),
			chk_row(ACT_TICK_10MS, F_NONE,  LV_PRECHARGE),
			req_row(ACT_TICK_10MS, F_ALL),                 // still waiting out 500 ticks
			chk_row(ACT_OPEN_ALL,  F_READY, LV_OPEN),
			// only the high bits set: the kept 13 bits are zero, a zero wait
			reg_row(CFG_IDX_PRECHARGE_TIME, 16'hE000),
			reg_row(CFG_IDX_OVERLAP_TICKS,  16'd2),
			reg_row(CFG_IDX_SPARE_A,        16'hFFFF),
			req_row(ACT_CLOSE_REQ, F_NONE),
			req_row(ACT_TICK_1S,   F_READY),
			req_row(ACT_TICK_1S,   F_READY),               // already running
			req_row(ACT_TICK_10MS, F_NONE),
			req_row(ACT_CLOSE_REQ, F_NONE),                // request mid-sequence
			req_row(ACT_TICK_10MS, F_NONE),
			chk_row(ACT_TICK_10MS, F_NONE,  LV_MAIN_ON),   // main close with pulse
			req_row(ACT_TICK_10MS, F_NONE),
			req_row(ACT_TICK_10MS, F_NONE),                // overlap done, request cleared
			req_row(ACT_TICK_1S,   F_READY),               // nothing pending: refused
			chk_row(ACT_OPEN_ALL,  F_NONE,  LV_OPEN),
			req_row(ACT_TICK_10MS, F_READY)
		};

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_steps[i]) begin
			if (directed_steps[i].is_reg)
				write_reg(directed_steps[i].reg_index, directed_steps[i].reg_value);
			else
				apply_request(directed_steps[i].req, directed_steps[i].has_want,
					directed_steps[i].want);
		end

		// Long sequence: 200 ticks of precharge wait, then a 300-tick overlap,
		// plus the close-precharge and close-main ticks and a few idle ticks.
		write_reg(CFG_IDX_PRECHARGE_TIME, 16'd20);
		write_reg(CFG_IDX_OVERLAP_TICKS,  16'd300);
		apply_request({ACT_CLOSE_REQ, F_READY}, 1'b0, LV_OPEN);
		apply_request({ACT_TICK_1S, F_READY}, 1'b0, LV_OPEN);
		for (int n = 0; n < 2 + 20 * TICKS_PER_UNIT + 300 + 4; n++) begin
			r        = random_req();
			r.action = ACT_TICK_10MS;
			apply_request(r, 1'b0, LV_OPEN);
		end
		apply_request({ACT_OPEN_ALL, F_NONE}, 1'b0, LV_OPEN);

		// Random phases, each with its own settings and idling mix.
		for (int ph = 0; ph < 5; ph++) begin
			ovl_val = (ph == 3) ? $urandom_range(40) : ovl_pick[ph];
			write_reg(CFG_IDX_PRECHARGE_TIME,
				{3'($urandom), 13'(ph == 3 ? $urandom_range(3) : pt_pick[ph])});
			write_reg(CFG_IDX_OVERLAP_TICKS, 16'(ovl_val));
			write_reg(($urandom_range(1) != 0) ? CFG_IDX_SPARE_A : CFG_IDX_SPARE_B,
				16'($urandom));
			send_idle_pct  = send_pick[ph];
			recv_stall_pct = recv_pick[ph];
			for (int n = 0; n < 180; n++) begin
				apply_request(random_req(), 1'b0, LV_OPEN);
				// now and then let everything drain before the next request
				if ($urandom_range(59) == 0)
					settle();
			end
		end

		settle();
		repeat (8) @(posedge clk);
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
